/* hdl/mbd_pkg.sv */
`default_nettype none

package mbd_pkg;

    // column count register is fixed at 16 bits
    localparam int COLS_BITS = 16;
    localparam logic [COLS_BITS-1:0] COLS_RESET = 16'd400;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = 2'd1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS = 2;
    localparam int LEVEL_BITS = 3;
    // a new sample is taken while the queue can absorb two more results
    localparam logic [LEVEL_BITS-1:0] LEVEL_ACCEPT_MAX = 3'd2;

endpackage

`default_nettype wire

/* hdl/minmax_bucket_decimator_unit.sv */
`default_nettype none

// Min/max bucket decimator. A frame of frame_length (time, value) samples
// streams in; when column_count is nonzero and the frame holds more than twice
// column_count samples, the frame is cut into column_count buckets with exact
// integer bucket ends floor((c+1)*n/cols), and at each bucket's last sample the
// first minimum and first maximum leave in sample order (one result when they
// are the same sample). Otherwise every sample passes through unchanged.
// One sample is accepted per clock while o_in_ready is high; its results enter
// a four-entry result queue at the accepting edge and leave one per clock while
// i_out_ready is high. If a sample yields results, o_out_valid is high right
// after that edge and the first can be taken at the next one. o_in_ready is high
// while the queue holds at most two entries, so with i_out_ready high one sample
// per cycle is sustained in both modes, as a bucket of at least two samples
// yields at most two results. Any configuration write restarts the frame.
module minmax_bucket_decimator_unit #(
    parameter int COUNT_BITS = 24,
    parameter int VALUE_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_we,
    input  wire  [mbd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [((COUNT_BITS > mbd_pkg::COLS_BITS) ? COUNT_BITS
                   : mbd_pkg::COLS_BITS)-1:0]  i_cfg_data,
    // sample channel
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [TIME_BITS-1:0]               i_sample_time,
    input  wire  signed [VALUE_BITS-1:0]       i_sample_value,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [TIME_BITS-1:0]               o_out_time,
    output logic signed [VALUE_BITS-1:0]       o_out_value,
    output logic                               o_run_last,
    output logic                               o_frame_last
);
    import mbd_pkg::*;

    localparam int SUM_BITS = COUNT_BITS + COLS_BITS;

    // configuration registers
    logic [COUNT_BITS-1:0] r_frame_length;
    logic [COLS_BITS-1:0]  r_column_count;

    // bucket state
    logic [COUNT_BITS-1:0] r_sample_index, n_sample_index;
    logic [SUM_BITS-1:0]   r_position_sum, n_position_sum;
    logic [SUM_BITS-1:0]   r_bucket_bound, n_bucket_bound;
    logic                  r_open, n_open;
    logic [COUNT_BITS-1:0] r_min_index, n_min_index, r_max_index, n_max_index;
    logic [TIME_BITS-1:0]  r_min_time, n_min_time, r_max_time, n_max_time;
    logic signed [VALUE_BITS-1:0] r_min_value, n_min_value, r_max_value, n_max_value;

    // result queue
    logic [TIME_BITS-1:0]         r_q_time  [QUEUE_DEPTH];
    logic signed [VALUE_BITS-1:0] r_q_value [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       r_q_run;
    logic [QUEUE_DEPTH-1:0]       r_q_frame;
    logic [PTR_BITS-1:0]          r_wr_ptr, r_rd_ptr;
    logic [LEVEL_BITS-1:0]        r_level;

    logic                   accept, pop;
    logic                   decimate, frame_end, bucket_close;
    logic [COUNT_BITS:0]    index_plus_one;
    logic [SUM_BITS-1:0]    twice_cols, frame_wide;
    logic [1:0]             push_count;
    logic [TIME_BITS-1:0]   res0_time, res1_time;
    logic signed [VALUE_BITS-1:0] res0_value, res1_value;
    logic [PTR_BITS-1:0]    wr_ptr_next;

    assign accept = i_in_valid && o_in_ready;
    assign pop    = o_out_valid && i_out_ready;

    assign o_in_ready   = (r_level <= LEVEL_ACCEPT_MAX);
    assign o_out_valid  = (r_level != '0);
    assign o_out_time   = r_q_time[r_rd_ptr];
    assign o_out_value  = r_q_value[r_rd_ptr];
    assign o_run_last   = r_q_run[r_rd_ptr];
    assign o_frame_last = r_q_frame[r_rd_ptr];

    assign index_plus_one = {1'b0, r_sample_index} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign twice_cols = {{(SUM_BITS-COLS_BITS-1){1'b0}}, r_column_count, 1'b0};
    assign frame_wide = {{COLS_BITS{1'b0}}, r_frame_length};
    assign frame_end  = (r_frame_length != '0)
                        && (index_plus_one >= {1'b0, r_frame_length});
    assign decimate   = (r_column_count != '0) && (frame_wide > twice_cols);
    assign bucket_close = (r_bucket_bound < r_position_sum) || frame_end;
    assign wr_ptr_next  = r_wr_ptr + PTR_BITS'(1);

    // per-sample bucket update and result selection
    always_comb begin
        n_min_index = r_min_index;
        n_min_time  = r_min_time;
        n_min_value = r_min_value;
        n_max_index = r_max_index;
        n_max_time  = r_max_time;
        n_max_value = r_max_value;
        n_open         = r_open;
        n_bucket_bound = r_bucket_bound;
        n_position_sum = r_position_sum;
        push_count  = 2'd0;
        res0_time   = i_sample_time;
        res0_value  = i_sample_value;
        res1_time   = i_sample_time;
        res1_value  = i_sample_value;

        if (!decimate) begin
            push_count = 2'd1;
        end else begin
            if (!r_open) begin
                n_min_index = r_sample_index;
                n_max_index = r_sample_index;
                n_min_time  = i_sample_time;
                n_max_time  = i_sample_time;
                n_min_value = i_sample_value;
                n_max_value = i_sample_value;
            end else begin
                if (i_sample_value < r_min_value) begin
                    n_min_index = r_sample_index;
                    n_min_time  = i_sample_time;
                    n_min_value = i_sample_value;
                end
                if (i_sample_value > r_max_value) begin
                    n_max_index = r_sample_index;
                    n_max_time  = i_sample_time;
                    n_max_value = i_sample_value;
                end
            end
            n_open = 1'b1;
            if (bucket_close) begin
                priority if (n_min_index == n_max_index) begin
                    push_count = 2'd1;
                    res0_time  = n_min_time;
                    res0_value = n_min_value;
                end else if (n_min_index < n_max_index) begin
                    push_count = 2'd2;
                    res0_time  = n_min_time;
                    res0_value = n_min_value;
                    res1_time  = n_max_time;
                    res1_value = n_max_value;
                end else begin
                    push_count = 2'd2;
                    res0_time  = n_max_time;
                    res0_value = n_max_value;
                    res1_time  = n_min_time;
                    res1_value = n_min_value;
                end
                n_open         = 1'b0;
                n_bucket_bound = r_bucket_bound + frame_wide;
            end
            n_position_sum = r_position_sum
                             + {{(SUM_BITS-COLS_BITS){1'b0}}, r_column_count};
        end

        if (frame_end) begin
            n_sample_index = '0;
            n_position_sum = twice_cols;
            n_bucket_bound = frame_wide;
            n_open         = 1'b0;
        end else if (r_frame_length != '0) begin
            n_sample_index = index_plus_one[COUNT_BITS-1:0];
        end else begin
            n_sample_index = r_sample_index;
        end
    end

    // configuration and bucket control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= '0;
            r_column_count <= COLS_RESET;
            r_sample_index <= '0;
            r_position_sum <= {{(SUM_BITS-COLS_BITS-1){1'b0}}, COLS_RESET, 1'b0};
            r_bucket_bound <= '0;
            r_open         <= 1'b0;
        end else if (i_cfg_we) begin
            // any write restarts the frame from the new register values
            r_sample_index <= '0;
            r_open         <= 1'b0;
            unique case (i_cfg_index)
                CFG_FRAME_LENGTH: begin
                    r_frame_length <= i_cfg_data[COUNT_BITS-1:0];
                    r_position_sum <= twice_cols;
                    r_bucket_bound <= {{COLS_BITS{1'b0}}, i_cfg_data[COUNT_BITS-1:0]};
                end
                CFG_COLUMN_COUNT: begin
                    r_column_count <= i_cfg_data[COLS_BITS-1:0];
                    r_position_sum <= {{(SUM_BITS-COLS_BITS-1){1'b0}},
                                       i_cfg_data[COLS_BITS-1:0], 1'b0};
                    r_bucket_bound <= frame_wide;
                end
                default: begin
                    r_position_sum <= twice_cols;
                    r_bucket_bound <= frame_wide;
                end
            endcase
        end else if (accept) begin
            r_sample_index <= n_sample_index;
            r_position_sum <= n_position_sum;
            r_bucket_bound <= n_bucket_bound;
            r_open         <= n_open;
        end
    end

    // running minimum and maximum, only read while a bucket is open
    always_ff @(posedge i_clk) begin
        if (accept && !i_cfg_we) begin
            r_min_index <= n_min_index;
            r_min_time  <= n_min_time;
            r_min_value <= n_min_value;
            r_max_index <= n_max_index;
            r_max_time  <= n_max_time;
            r_max_value <= n_max_value;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (accept && !i_cfg_we && push_count != 2'd0) begin
            r_q_time[r_wr_ptr]  <= res0_time;
            r_q_value[r_wr_ptr] <= res0_value;
            r_q_run[r_wr_ptr]   <= (push_count == 2'd1);
            r_q_frame[r_wr_ptr] <= frame_end;
            if (push_count == 2'd2) begin
                r_q_time[wr_ptr_next]  <= res1_time;
                r_q_value[wr_ptr_next] <= res1_value;
                r_q_run[wr_ptr_next]   <= 1'b1;
                r_q_frame[wr_ptr_next] <= frame_end;
            end
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (accept && !i_cfg_we) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(push_count);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_level <= r_level
                       + ((accept && !i_cfg_we) ? LEVEL_BITS'(push_count) : '0)
                       - (pop ? LEVEL_BITS'(1) : '0);
        end
    end

endmodule

`default_nettype wire

/* dv/minmax_bucket_decimator_unit_test.sv */
module minmax_bucket_decimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_SAMPLES = 576;
    localparam int QUIET_TAIL = 120;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_IDX_BITS-1:0]   reg_index;
        logic [23:0]               reg_data;
        logic [31:0]               stamp;
        logic signed [15:0]        level;
        logic                      fixed_exp;
    } t_stim_row;

    typedef struct {
        logic [31:0]        out_time;
        logic signed [15:0] out_value;
        logic               run_last;
        logic               frame_last;
    } t_sample_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = CFG_FRAME_LENGTH;
    logic [23:0]               i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [31:0]               i_sample_time = '0;
    logic signed [15:0]        i_sample_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [31:0]               o_out_time;
    logic signed [15:0]        o_out_value;
    logic                      o_run_last;
    logic                      o_frame_last;

    minmax_bucket_decimator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_time     (o_out_time),
        .o_out_value    (o_out_value),
        .o_run_last     (o_run_last),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decimator state mirror
    logic [23:0]        frame_len;
    logic [15:0]        col_cnt;
    logic [23:0]        smp_idx;
    logic [63:0]        pos_sum;
    logic [63:0]        bkt_bound;
    logic [23:0]        min_idx, max_idx;
    logic [31:0]        min_stamp, max_stamp;
    logic signed [15:0] min_level, max_level;
    bit                 bkt_open;

    t_sample_point pending_points[$];

    int  mismatch_count = 0;
    int  samples_sent = 0;
    int  points_seen = 0;
    int  reg_writes = 0;
    int  in_stall_cycles = 0;
    int  cycle_count = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    bit  arm_hold = 1'b0;
    bit  hold_req = 1'b0;

    t_stim_row directed_rows [DIRECTED_ROWS];

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void restart_frame();
        smp_idx = '0;
        pos_sum = 64'(col_cnt) * 2;
        bkt_bound = 64'(frame_len);
        min_idx = '0;
        max_idx = '0;
        min_stamp = '0;
        max_stamp = '0;
        min_level = '0;
        max_level = '0;
        bkt_open = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] index,
                                            input logic [23:0] data);
        if (index == CFG_FRAME_LENGTH) begin
            frame_len = data;
        end else if (index == CFG_COLUMN_COUNT) begin
            col_cnt = data[15:0];
        end
        // any write, mapped or not, starts a new frame
        restart_frame();
    endfunction

    task automatic decimate_sample(input logic [31:0] stamp, input logic signed [15:0] level);
        int unsigned   n;
        int unsigned   cols;
        bit            at_end;
        t_sample_point outs[$];
        n = 32'(frame_len);
        cols = 32'(col_cnt);
        at_end = (n != 0) && (32'(smp_idx) + 1 >= n);
        if (cols == 0 || n <= 2 * cols) begin
            outs.push_back('{stamp, level, 1'b0, at_end});
        end else begin
            if (!bkt_open) begin
                bkt_open = 1'b1;
                min_idx = smp_idx;
                max_idx = smp_idx;
                min_stamp = stamp;
                max_stamp = stamp;
                min_level = level;
                max_level = level;
            end else begin
                if (level < min_level) begin
                    min_idx = smp_idx;
                    min_stamp = stamp;
                    min_level = level;
                end
                if (level > max_level) begin
                    max_idx = smp_idx;
                    max_stamp = stamp;
                    max_level = level;
                end
            end
            // bucket closes once (c+1)*n falls below (i+2)*cols or the frame ends
            if (bkt_bound < pos_sum || at_end) begin
                if (min_idx == max_idx) begin
                    outs.push_back('{min_stamp, min_level, 1'b0, at_end});
                end else if (min_idx < max_idx) begin
                    outs.push_back('{min_stamp, min_level, 1'b0, at_end});
                    outs.push_back('{max_stamp, max_level, 1'b0, at_end});
                end else begin
                    outs.push_back('{max_stamp, max_level, 1'b0, at_end});
                    outs.push_back('{min_stamp, min_level, 1'b0, at_end});
                end
                bkt_open = 1'b0;
                bkt_bound += 64'(n);
            end
            pos_sum += 64'(cols);
        end
        if (outs.size() > 0) begin
            outs[outs.size() - 1].run_last = 1'b1;
        end
        foreach (outs[k]) begin
            pending_points.push_back(outs[k]);
        end
        if (at_end) begin
            restart_frame();
        end else if (n != 0) begin
            smp_idx = 24'(smp_idx + 24'd1);
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic offer_sample(input logic [31:0] stamp, input logic signed [15:0] level,
                                input bit fixed_exp);
        int gap;
        if (send_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_time <= stamp;
        i_sample_value <= level;
        @(posedge i_clk);
        while (!o_in_ready) begin
            in_stall_cycles++;
            @(posedge i_clk);
        end
        if (fixed_exp) begin
            pending_points.push_back('{stamp, level, 1'b1, 1'b0});
        end else begin
            decimate_sample(stamp, level);
        end
        samples_sent++;
        if (arm_hold) begin
            hold_req = 1'b1;
            arm_hold = 1'b0;
        end
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        // a sample that closes no bucket leaves nothing to wait for
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg_write(index, data);
        reg_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_level();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            // narrow range makes ties between min and max common
            return $signed(16'($urandom_range(0, 6))) - 16'sd3;
        end else if (sel == 3) begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        end
        return 16'($urandom);
    endfunction

    task automatic run_phase(input logic [23:0] n, input logic [15:0] cols, input int items);
        settle_block();
        write_reg(CFG_FRAME_LENGTH, n);
        write_reg(CFG_COLUMN_COUNT, {8'd0, cols});
        for (int k = 0; k < items; k++) begin
            offer_sample($urandom, pick_level(), 1'b0);
        end
    endtask

    // result side: random stalls plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_points
        t_sample_point want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point time=%h value=%0d",
                                          o_out_time, o_out_value));
            end else begin
                want = pending_points.pop_front();
                if (o_out_time !== want.out_time) begin
                    report_mismatch($sformatf("out_time %h, want %h",
                                              o_out_time, want.out_time));
                end
                if (o_out_value !== want.out_value) begin
                    report_mismatch($sformatf("out_value %0d, want %0d",
                                              o_out_value, want.out_value));
                end
                if (o_run_last !== want.run_last) begin
                    report_mismatch($sformatf("run_last %b, want %b",
                                              o_run_last, want.run_last));
                end
                if (o_frame_last !== want.frame_last) begin
                    report_mismatch($sformatf("frame_last %b, want %b",
                                              o_frame_last, want.frame_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, pending_points.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          kind;
        int          n;
        int          cols;
        int          items;
        int          tail_wait;
        t_stim_row   row;

        directed_rows = '{
            // after reset: zero frame length, plain pass-through
            '{ROW_SAMPLE, '0, 24'd0, 32'h0000_0000, 16'sh0000, 1'b1},
            '{ROW_SAMPLE, '0, 24'd0, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1},
            '{ROW_SAMPLE, '0, 24'd0, 32'h0000_0000, 16'sh8000, 1'b1},
            '{ROW_SAMPLE, '0, 24'd0, 32'hA5A5_A5A5, 16'sh5A5A, 1'b1},
            '{ROW_SAMPLE, '0, 24'd0, 32'h5A5A_5A5A, 16'shA5A5, 1'b1},
            // five samples in two buckets: ends at 2 and 5
            '{ROW_WRITE, CFG_FRAME_LENGTH, 24'd5, 32'h0, 16'sh0, 1'b0},
            '{ROW_WRITE, CFG_COLUMN_COUNT, 24'd2, 32'h0, 16'sh0, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd100, 16'sh7FFF, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd101, 16'sh8000, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd102, 16'sd0, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd103, -16'sd9, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd104, 16'sd9, 1'b0},
            // min before max, then one bucket where min and max coincide
            '{ROW_SAMPLE, '0, 24'd0, 32'd110, -16'sd5, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd111, 16'sd5, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd112, 16'sd2, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd113, 16'sd2, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd114, 16'sd2, 1'b0},
            // zero columns: pass-through with a frame end
            '{ROW_WRITE, CFG_COLUMN_COUNT, 24'd0, 32'h0, 16'sh0, 1'b0},
            '{ROW_WRITE, CFG_FRAME_LENGTH, 24'd3, 32'h0, 16'sh0, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd200, 16'sd7, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd201, -16'sd7, 1'b0},
            // unmapped write still restarts the frame
            '{ROW_SAMPLE, '0, 24'd0, 32'd202, 16'sd0, 1'b0},
            '{ROW_WRITE, CFG_UNMAPPED, 24'hFFFFFF, 32'h0, 16'sh0, 1'b0},
            '{ROW_SAMPLE, '0, 24'd0, 32'd203, 16'sd1, 1'b0}
        };

        frame_len = '0;
        col_cnt = COLS_RESET;
        restart_frame();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                settle_block();
                write_reg(row.reg_index, row.reg_data);
            end else begin
                offer_sample(row.stamp, row.level, row.fixed_exp);
            end
        end

        // largest registers; bucket 0 of the full-size frame closes at sample 255
        run_phase(24'hFFFFFF, 16'hFFFF, 260);
        run_phase(24'hFFFFFF, 16'h0000, 15);
        run_phase(24'hFFFFFF, 16'h0001, 15);
        run_phase(24'd20, 16'hFFFF, 25);

        // back-to-back transactions into a stalled receiver
        send_idle = 1'b0;
        arm_hold = 1'b1;
        run_phase(24'd0, 16'd0, 60);
        send_idle = 1'b1;

        while (samples_sent < DIRECTED_ROWS + RANDOM_SAMPLES) begin
            if (samples_sent > DIRECTED_ROWS + RANDOM_SAMPLES - QUIET_TAIL) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                run_phase(24'($urandom_range(0, 12)), 16'd0, $urandom_range(5, 25));
            end else if (kind == 1) begin
                n = $urandom_range(1, 30);
                cols = $urandom_range((n + 1) / 2, 65535);
                run_phase(24'(n), 16'(cols), $urandom_range(10, 30));
            end else if (kind == 2) begin
                settle_block();
                write_reg(CFG_UNMAPPED, 24'($urandom));
                for (int k = 0; k < 20; k++) begin
                    offer_sample($urandom, pick_level(), 1'b0);
                end
            end else begin
                n = $urandom_range(3, 64);
                cols = $urandom_range(1, (n - 1) / 2);
                items = n * $urandom_range(1, 3) + $urandom_range(0, n - 1);
                run_phase(24'(n), 16'(cols), items);
            end
        end

        i_in_valid <= 1'b0;
        tail_wait = 0;
        while (pending_points.size() != 0 && tail_wait < 5000) begin
            @(negedge i_clk);
            tail_wait++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_points.size() != 0) begin
            report_mismatch($sformatf("%0d points never arrived", pending_points.size()));
        end

        $display("run covered %0d samples over %0d register writes, %0d points checked",
                 samples_sent, reg_writes, points_seen);
        $display("input held off %0d cycles by backpressure, %0d mismatches",
                 in_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mbd_pkg.sv
hdl/minmax_bucket_decimator_unit.sv
dv/minmax_bucket_decimator_unit_test.sv
